@@ rtl/core/rau_pkg.sv @@
package rau_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_MUL    = 2'd1;
    localparam logic [1:0] FUNC_DIV    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] SEL_P0 = 2'd0;
    localparam logic [1:0] SEL_P1 = 2'd1;
    localparam logic [1:0] SEL_P2 = 2'd2;

    localparam int DivSteps = 64;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] lhs_num;
        logic [30:0]        lhs_den;
        logic signed [31:0] rhs_num;
        logic [30:0]        rhs_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic               status;
    } rau_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_MAG,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } rau_state_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic [1:0] mul_sel;
        logic       sum;
        logic       mag;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } rau_cmd_t;

    typedef struct packed {
        logic special;
        logic gcd_done;
    } rau_sts_t;

endpackage

@@ rtl/core/rau_ctrl.sv @@
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_cmd_t cmd
);
    import rau_pkg::*;

    rau_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_MUL0;
            ST_MUL0: state_next = sts.special ? ST_DONE : ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SUM;
            ST_SUM:  state_next = ST_MAG;
            ST_MAG:  state_next = ST_GCD;
            ST_GCD:  if (sts.gcd_done) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 6'(DivSteps - 1)) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: cmd.load = req_valid;
            ST_MUL0:
            begin
                cmd.mul = 1'b1;
                cmd.mul_sel = SEL_P0;
            end
            ST_MUL1:
            begin
                cmd.mul = 1'b1;
                cmd.mul_sel = SEL_P1;
            end
            ST_MUL2:
            begin
                cmd.mul = 1'b1;
                cmd.mul_sel = SEL_P2;
            end
            ST_SUM:  cmd.sum = 1'b1;
            ST_MAG:  cmd.mag = 1'b1;
            ST_GCD:
            begin
                cnt_next = '0;
                if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/rau_dp.sv @@
module rau_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic              clk,
    input  rau_pkg::rau_in_t  req,
    input  rau_pkg::rau_cmd_t cmd,
    output rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_out_t rsp
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [1:0]         func_reg;
    logic signed [32:0] a_reg, b_reg, c_reg, d_reg;
    logic               special_reg, err_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, num_reg;
    logic [63:0]        ga_reg, gb_reg, g_reg;
    logic [5:0]         shift_reg;
    logic               neg_reg;
    logic [63:0]        qn_reg, qd_reg, rn_reg, rd_reg;
    rau_out_t           out_reg;

    logic signed [32:0] a_in, b_in, c_in, d_in, mx, my;
    logic signed [65:0] prod;
    logic [63:0]        mn, md, gval, gsh;
    logic [64:0]        tn, td;

    assign a_in = 33'(signed'(req.lhs_num[W-1:0]));
    assign c_in = 33'(signed'(req.rhs_num[W-1:0]));
    assign b_in = {{(34-W){1'b0}}, req.lhs_den[W-2:0]};
    assign d_in = {{(34-W){1'b0}}, req.rhs_den[W-2:0]};

    always_comb
    begin
        case (cmd.mul_sel)
            SEL_P0:
            begin
                mx = a_reg;
                my = (func_reg == FUNC_MUL) ? c_reg : d_reg;
            end
            SEL_P1:
            begin
                mx = c_reg;
                my = (func_reg == FUNC_ADD) ? b_reg : '0;
            end
            default:
            begin
                mx = b_reg;
                my = (func_reg == FUNC_DIV) ? c_reg : d_reg;
            end
        endcase
    end

    assign prod = mx * my;

    assign mn = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign md = p2_reg[63] ? 64'(-p2_reg) : 64'(p2_reg);

    assign gval = ga_reg | gb_reg;
    assign gsh  = gval << shift_reg;

    assign tn = {rn_reg, qn_reg[63]};
    assign td = {rd_reg, qd_reg[63]};

    assign sts.special  = special_reg;
    assign sts.gcd_done = (ga_reg == '0) || (gb_reg == '0);
    assign rsp = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req.func;
            a_reg <= a_in;
            b_reg <= b_in;
            c_reg <= c_in;
            d_reg <= d_in;
            err_reg <= (req.func == FUNC_DIV) && (c_in == '0);
            special_reg <= (req.func == FUNC_UNUSED) ||
                           ((req.func == FUNC_DIV) && (c_in == '0));
        end
        if (cmd.mul)
        begin
            case (cmd.mul_sel)
                SEL_P0:  p0_reg <= prod[63:0];
                SEL_P1:  p1_reg <= prod[63:0];
                default: p2_reg <= prod[63:0];
            endcase
        end
        if (cmd.sum)
        begin
            num_reg <= p0_reg + p1_reg;
        end
        if (cmd.mag)
        begin
            ga_reg <= mn;
            gb_reg <= md;
            qn_reg <= mn;
            qd_reg <= md;
            shift_reg <= '0;
            neg_reg <= num_reg[63] != p2_reg[63];
        end
        if (cmd.gcd_step)
        begin
            if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                shift_reg <= shift_reg + 6'd1;
            end
            else if (!ga_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
            end
            else if (!gb_reg[0])
            begin
                gb_reg <= gb_reg >> 1;
            end
            else if (ga_reg >= gb_reg)
            begin
                ga_reg <= ga_reg - gb_reg;
            end
            else
            begin
                gb_reg <= gb_reg - ga_reg;
            end
        end
        if (cmd.div_init)
        begin
            g_reg <= (gval == '0) ? 64'd1 : gsh;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (tn >= {1'b0, g_reg})
            begin
                rn_reg <= 64'(tn - {1'b0, g_reg});
                qn_reg <= {qn_reg[62:0], 1'b1};
            end
            else
            begin
                rn_reg <= tn[63:0];
                qn_reg <= {qn_reg[62:0], 1'b0};
            end
            if (td >= {1'b0, g_reg})
            begin
                rd_reg <= 64'(td - {1'b0, g_reg});
                qd_reg <= {qd_reg[62:0], 1'b1};
            end
            else
            begin
                rd_reg <= td[63:0];
                qd_reg <= {qd_reg[62:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            if (special_reg)
            begin
                out_reg.res_num <= '0;
                out_reg.res_den <= 63'd1;
                out_reg.status <= err_reg;
            end
            else
            begin
                out_reg.res_num <= neg_reg ? -$signed(qn_reg) : $signed(qn_reg);
                out_reg.res_den <= qd_reg[62:0];
                out_reg.status <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/rational_arith_unit.sv @@
// Exact add, multiply or divide of two fractions, reduced to lowest terms.
// The request channel (req_valid, req_stall, req) carries one item: an
// operation code and two fractions, each a signed numerator over a positive
// denominator. The response channel (rsp_valid, rsp_stall, rsp) returns one
// item per request: the reduced numerator, a positive denominator and a
// status bit that flags a division by a zero numerator.
// One item is in work at a time. A request runs the products P0, P1 and P2
// on one shared 33 by 33 bit multiplier, a sum step and a sign and magnitude
// step, the binary GCD loop at one step a cycle, and a restoring division
// of numerator and denominator by the divisor in parallel over DivSteps
// steps. An unused operation code or a division by zero goes from the first
// multiplication step straight to the final state.
// The result sits in an output register, so a new request is taken while a
// finished result still waits; if the receiver keeps stalling, the next item
// waits in its final state until the output register is free.
// Reset clears the controller and the response valid; no clearing pass.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  rau_pkg::rau_in_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rau_pkg::rau_out_t rsp
);
    import rau_pkg::*;

    rau_cmd_t cmd;
    rau_sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk (clk),
        .req (req),
        .cmd (cmd),
        .sts (sts),
        .rsp (rsp)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted but block not busy");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.res_num == '0 && rsp.res_den == 63'd1))
        else $error("error result is not 0/1");

endmodule
